// File: sv/ptm_pkg.sv
// ptm_pkg: shared types, constants and descriptor helpers for the page table updater
// no dependencies; used by every module of the block except ptm_table_ram

package ptm_pkg;

   // pool geometry
   localparam int TABLE_PAGES  = 16;
   localparam int IDX_W        = 9;
   localparam int PAGE_W       = $clog2(TABLE_PAGES);
   localparam int NFT_W        = $clog2(TABLE_PAGES + 1);
   localparam int SLOT_W       = PAGE_W + IDX_W;
   localparam int TABLE_DEPTH  = TABLE_PAGES * (1 << IDX_W);
   localparam int FRAME_W      = 36;

   // word field widths
   localparam int VA_W         = 39;
   localparam int PA_W         = 48;
   localparam int FLAGS_W      = 3;
   localparam int STATUS_W     = 3;
   localparam int DESC_W       = 64;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MAPPED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNMAPPED   = 3'd4;

   // operation codes
   localparam logic FUNC_MAP   = 1'b0;
   localparam logic FUNC_UNMAP = 1'b1;

   // descriptor bits
   localparam logic [DESC_W-1:0] ADDR_MASK     = 64'h0000_FFFF_FFFF_F000;
   localparam logic [DESC_W-1:0] DESC_VALID    = 64'h3;
   localparam logic [DESC_W-1:0] BIT_AF        = 64'h1 << 10;
   localparam logic [DESC_W-1:0] BIT_PXN       = 64'h1 << 53;
   localparam logic [DESC_W-1:0] BIT_UXN       = 64'h1 << 54;
   localparam logic [DESC_W-1:0] SH_INNER_BITS = 64'h3 << 8;
   localparam logic [DESC_W-1:0] AP_USER_BIT   = 64'h1 << 6;
   localparam logic [DESC_W-1:0] ATTR_DEVICE   = 64'h1 << 2;

   // walk levels
   localparam logic [1:0] LVL_L1 = 2'd0;
   localparam logic [1:0] LVL_L2 = 2'd1;
   localparam logic [1:0] LVL_L3 = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_EVAL,
      S_DONE
   } state_type;

   // result of the link decode and table address unit
   typedef struct packed {
      logic              ok;
      logic [PAGE_W-1:0] page;
      logic [FRAME_W-1:0] new_frame;
   } link_res_type;

   function automatic logic [DESC_W-1:0] page_desc(input logic [PA_W-1:0] pa,
                                                   input logic [FLAGS_W-1:0] flags);
      logic              dev;
      logic              nx;
      logic              usr;
      logic [DESC_W-1:0] d;
      dev = flags[0];
      nx  = flags[1];
      usr = flags[2];
      d = ({16'b0, pa} & ADDR_MASK) | DESC_VALID | BIT_AF;
      d = d | (dev ? ATTR_DEVICE : SH_INNER_BITS);
      if (usr) begin
         d = d | AP_USER_BIT | BIT_PXN;
         if (nx) begin
            d = d | BIT_UXN;
         end
      end else begin
         d = d | BIT_UXN;
         if (dev || nx) begin
            d = d | BIT_PXN;
         end
      end
      return d;
   endfunction

endpackage

// File: sv/ptm_req_if.sv
// ptm_req_if: request channel, valid/ready plus one map or unmap word
// depends on ptm_pkg for field widths

interface ptm_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [ptm_pkg::VA_W-1:0]      virt_addr;
   logic [ptm_pkg::PA_W-1:0]      phys_addr;
   logic [ptm_pkg::FLAGS_W-1:0]   map_flags;

   modport source (output valid, func, virt_addr, phys_addr, map_flags, input ready);
   modport sink   (input valid, func, virt_addr, phys_addr, map_flags, output ready);
endinterface

// File: sv/ptm_rsp_if.sv
// ptm_rsp_if: response channel, valid/ready plus status and written descriptor
// depends on ptm_pkg for field widths

interface ptm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ptm_pkg::STATUS_W-1:0]  status;
   logic [ptm_pkg::DESC_W-1:0]    page_descriptor;

   modport source (output valid, status, page_descriptor, input ready);
   modport sink   (input valid, status, page_descriptor, output ready);
endinterface

// File: sv/page_table_map_unmap.sv
// Page table map/unmap engine for a three-level, 512-entry-per-level table with 4 KB pages
// and a 39-bit virtual address. The table lives in one single-port memory of
// TABLE_PAGES x 512 64-bit entries; page 0 is the root and new table pages are handed out
// in order and never freed. After reset the block sweeps the whole memory to zero, one
// entry per cycle over all TABLE_PAGES * 512 = 8192 entries, with req_chan.ready low; csr writes
// are taken during the sweep. A request word is then taken when the engine is idle. A
// misaligned request goes from S_IDLE to S_DONE, which loads the response register once
// it is free. Any other request walks up to three levels, each level a memory read state
// (S_READ) and an evaluate state (S_EVAL, which also does any write), and S_DONE then
// hands the result to the response register. No new request is taken until S_DONE has
// loaded the response register and the engine is back in S_IDLE. The response sits in
// an output register, so the next request is taken while a response still waits for
// rsp_chan.ready. csr_wdata is the table pool base (low 12 bits ignored); write it only
// while no request is in flight.
// depends on ptm_pkg, ptm_req_if, ptm_rsp_if, ptm_table_ram, ptm_link_unit

module page_table_map_unmap (
   input  logic                      clock,
   input  logic                      reset,
   ptm_req_if.sink                   req_chan,
   ptm_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [ptm_pkg::PA_W-1:0]  csr_wdata
);

   // control state
   ptm_pkg::state_type              state_ff, state_in;
   logic [ptm_pkg::SLOT_W-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [1:0]                      level_ff, level_in;
   logic [ptm_pkg::PAGE_W-1:0]      page_ff, page_in;
   logic [ptm_pkg::NFT_W-1:0]       nft_ff, nft_in;
   logic                            rsp_valid_ff;
   logic [ptm_pkg::PA_W-1:0]        base_ff;

   // captured request word
   logic                            func_ff, func_in;
   logic [3*ptm_pkg::IDX_W-1:0]     vidx_ff, vidx_in;
   logic [ptm_pkg::PA_W-1:0]        pa_ff, pa_in;
   logic [ptm_pkg::FLAGS_W-1:0]     flags_ff, flags_in;

   // pending result and response register
   logic [ptm_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [ptm_pkg::DESC_W-1:0]      res_desc_ff, res_desc_in;
   logic [ptm_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic [ptm_pkg::DESC_W-1:0]      rsp_desc_ff;
   logic                            rsp_load;

   // memory port
   logic                            ram_en;
   logic                            ram_we;
   logic [ptm_pkg::SLOT_W-1:0]      ram_addr;
   logic [ptm_pkg::DESC_W-1:0]      ram_wdata;
   logic [ptm_pkg::DESC_W-1:0]      ram_rdata;

   logic [ptm_pkg::IDX_W-1:0]       cur_idx;
   logic [ptm_pkg::SLOT_W-1:0]      walk_slot;
   logic                            misaligned;
   logic                            pool_full;
   ptm_pkg::link_res_type           lnk;

   ptm_table_ram #(
      .Width (ptm_pkg::DESC_W),
      .Depth (ptm_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   ptm_link_unit u_link (
      .entry     (ram_rdata),
      .pool_base (base_ff),
      .next_free (nft_ff),
      .res       (lnk)
   );

   // index for the level being walked: L1 va[38:30], L2 va[29:21], L3 va[20:12]
   always_comb begin
      case (level_ff)
         ptm_pkg::LVL_L1: cur_idx = vidx_ff[3*ptm_pkg::IDX_W-1:2*ptm_pkg::IDX_W];
         ptm_pkg::LVL_L2: cur_idx = vidx_ff[2*ptm_pkg::IDX_W-1:ptm_pkg::IDX_W];
         default:         cur_idx = vidx_ff[ptm_pkg::IDX_W-1:0];
      endcase
   end

   assign walk_slot = {page_ff, cur_idx};
   assign pool_full = (nft_ff >= ptm_pkg::NFT_W'(ptm_pkg::TABLE_PAGES));

   // unmap only checks the virtual address
   assign misaligned = (req_chan.virt_addr[11:0] != 12'h0) ||
                       ((req_chan.func == ptm_pkg::FUNC_MAP) &&
                        (req_chan.phys_addr[11:0] != 12'h0));

   assign rsp_load = (state_ff == ptm_pkg::S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // sequencer: next state, memory port and walk bookkeeping
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      level_in      = level_ff;
      page_in       = page_ff;
      nft_in        = nft_ff;
      func_in       = func_ff;
      vidx_in       = vidx_ff;
      pa_in         = pa_ff;
      flags_in      = flags_ff;
      res_status_in = res_status_ff;
      res_desc_in   = res_desc_ff;
      ram_en        = 1'b0;
      ram_we        = 1'b0;
      ram_addr      = walk_slot;
      ram_wdata     = '0;
      req_chan.ready = 1'b0;

      case (state_ff)
         ptm_pkg::S_CLEAR: begin
            // zero sweep over the whole pool
            ram_en     = 1'b1;
            ram_we     = 1'b1;
            ram_addr   = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ptm_pkg::SLOT_W'(ptm_pkg::TABLE_DEPTH - 1)) begin
               state_in = ptm_pkg::S_IDLE;
            end
         end

         ptm_pkg::S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               func_in       = req_chan.func;
               vidx_in       = req_chan.virt_addr[ptm_pkg::VA_W-1:12];
               pa_in         = req_chan.phys_addr;
               flags_in      = req_chan.map_flags;
               level_in      = ptm_pkg::LVL_L1;
               page_in       = '0;
               res_status_in = ptm_pkg::ST_OK;
               res_desc_in   = '0;
               if (misaligned) begin
                  res_status_in = ptm_pkg::ST_MISALIGNED;
                  state_in      = ptm_pkg::S_DONE;
               end else begin
                  state_in = ptm_pkg::S_READ;
               end
            end
         end

         ptm_pkg::S_READ: begin
            ram_en   = 1'b1;
            state_in = ptm_pkg::S_EVAL;
         end

         ptm_pkg::S_EVAL: begin
            if (level_ff != ptm_pkg::LVL_L3) begin
               // table level: follow, allocate or give up
               if (func_ff == ptm_pkg::FUNC_MAP && ram_rdata == '0) begin
                  if (pool_full) begin
                     res_status_in = ptm_pkg::ST_EXHAUSTED;
                     state_in      = ptm_pkg::S_DONE;
                  end else begin
                     ram_en    = 1'b1;
                     ram_we    = 1'b1;
                     ram_wdata = {16'b0, lnk.new_frame, 12'b0} | ptm_pkg::DESC_VALID;
                     nft_in    = nft_ff + 1'b1;
                     page_in   = nft_ff[ptm_pkg::PAGE_W-1:0];
                     level_in  = level_ff + 1'b1;
                     state_in  = ptm_pkg::S_READ;
                  end
               end else if (lnk.ok) begin
                  page_in  = lnk.page;
                  level_in = level_ff + 1'b1;
                  state_in = ptm_pkg::S_READ;
               end else begin
                  res_status_in = (func_ff == ptm_pkg::FUNC_MAP) ? ptm_pkg::ST_MAPPED
                                                                 : ptm_pkg::ST_UNMAPPED;
                  state_in      = ptm_pkg::S_DONE;
               end
            end else begin
               // leaf level
               state_in = ptm_pkg::S_DONE;
               if (func_ff == ptm_pkg::FUNC_MAP) begin
                  if (ram_rdata != '0) begin
                     res_status_in = ptm_pkg::ST_MAPPED;
                  end else begin
                     ram_en      = 1'b1;
                     ram_we      = 1'b1;
                     ram_wdata   = ptm_pkg::page_desc(pa_ff, flags_ff);
                     res_desc_in = ptm_pkg::page_desc(pa_ff, flags_ff);
                  end
               end else begin
                  if (ram_rdata == '0) begin
                     res_status_in = ptm_pkg::ST_UNMAPPED;
                  end else begin
                     ram_en    = 1'b1;
                     ram_we    = 1'b1;
                     ram_wdata = '0;
                  end
               end
            end
         end

         ptm_pkg::S_DONE: begin
            // wait for the response register to free up
            if (rsp_load) begin
               state_in = ptm_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ptm_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptm_pkg::S_CLEAR;
         clr_cnt_ff   <= '0;
         level_ff     <= ptm_pkg::LVL_L1;
         page_ff      <= '0;
         nft_ff       <= ptm_pkg::NFT_W'(1);
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         level_ff   <= level_in;
         page_ff    <= page_in;
         nft_ff     <= nft_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      vidx_ff       <= vidx_in;
      pa_ff         <= pa_in;
      flags_ff      <= flags_in;
      res_status_ff <= res_status_in;
      res_desc_ff   <= res_desc_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_desc_ff   <= res_desc_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.page_descriptor = rsp_desc_ff;

`ifndef SYNTH
   // pool counter only ever steps up by one
   a_nft_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && nft_ff != $past(nft_ff)) |-> (nft_ff == $past(nft_ff) + 1'b1))
      else $error("table pool counter jumped");

   // pool counter stays within the pool
   a_nft_range: assert property (@(posedge clock) disable iff (reset)
      (nft_ff != '0) && (nft_ff <= ptm_pkg::NFT_W'(ptm_pkg::TABLE_PAGES)))
      else $error("table pool counter out of range");

   // walk writes only land in allocated table pages
   a_write_alloc: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == ptm_pkg::S_EVAL) |->
         (ptm_pkg::NFT_W'(ram_addr[ptm_pkg::SLOT_W-1:ptm_pkg::IDX_W]) < nft_ff))
      else $error("table write outside allocated pages");

   // only a successful response carries a descriptor
   a_desc_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != ptm_pkg::ST_OK) |->
         (rsp_chan.page_descriptor == '0))
      else $error("descriptor on failed response");
`endif

endmodule

// File: sv/ptm_table_ram.sv
// ptm_table_ram: single-port table memory, one read or write per cycle
// registered read data; no package dependency

module ptm_table_ram #(
   parameter int Width = 64,
   parameter int Depth = 8192
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/ptm_link_unit.sv
// ptm_link_unit: shared frame arithmetic for the walk
// decodes a table link into a pool page and forms the frame of a new table
// depends on ptm_pkg

module ptm_link_unit (
   input  logic [ptm_pkg::DESC_W-1:0] entry,
   input  logic [ptm_pkg::PA_W-1:0]   pool_base,
   input  logic [ptm_pkg::NFT_W-1:0]  next_free,
   output ptm_pkg::link_res_type      res
);

   logic [ptm_pkg::FRAME_W-1:0] base_frame;
   logic [ptm_pkg::FRAME_W-1:0] offset;
   logic [ptm_pkg::FRAME_W-1:0] nft_ext;

   assign base_frame = pool_base[ptm_pkg::PA_W-1:12];
   assign nft_ext    = ptm_pkg::FRAME_W'(next_free);

   // offset wraps modulo the 48-bit address space
   assign offset = entry[ptm_pkg::PA_W-1:12] - base_frame;

   always_comb begin
      res.ok        = (entry[1:0] == 2'b11) && (offset != '0) && (offset < nft_ext);
      res.page      = offset[ptm_pkg::PAGE_W-1:0];
      res.new_frame = base_frame + nft_ext;
   end

endmodule

// File: sim/tb_page_table_map_unmap.sv
// testbench for page_table_map_unmap: map and unmap words against a local table predictor
// depends on ptm_pkg, ptm_req_if, ptm_rsp_if and the page_table_map_unmap rtl

`timescale 1ns / 1ps

module tb_page_table_map_unmap;

   // one request word and one response word as the predictor sees them
   typedef struct packed {
      logic                         func;
      logic [ptm_pkg::VA_W-1:0]     virt_addr;
      logic [ptm_pkg::PA_W-1:0]     phys_addr;
      logic [ptm_pkg::FLAGS_W-1:0]  map_flags;
   } map_req_type;

   typedef struct packed {
      logic [ptm_pkg::STATUS_W-1:0] status;
      logic [ptm_pkg::DESC_W-1:0]   page_descriptor;
   } map_rsp_type;

   localparam int                       ENTRIES_PER_PAGE = 1 << ptm_pkg::IDX_W;
   localparam logic [ptm_pkg::PA_W-1:0] FRAME_MASK       =
      ptm_pkg::ADDR_MASK[ptm_pkg::PA_W-1:0];
   localparam int                       HOLDOFF_CYCLES   = 400;
   localparam int                       HOLDOFF_AFTER    = 120;
   localparam int                       PHASE_WORDS      = 400;
   localparam int                       DRAIN_CYCLES     = 16;

   logic clock;
   logic reset = 1'b1;

   // tb-side copies of everything driven into the block, known from time zero
   logic                      drv_valid   = 1'b0;
   map_req_type               drv_word    = '0;
   logic                      rsp_ready_q = 1'b0;
   logic                      csr_we_q    = 1'b0;
   logic [ptm_pkg::PA_W-1:0]  csr_wdata_q = '0;

   ptm_req_if req_chan ();
   ptm_rsp_if rsp_chan ();

   assign req_chan.valid     = drv_valid;
   assign req_chan.func      = drv_word.func;
   assign req_chan.virt_addr = drv_word.virt_addr;
   assign req_chan.phys_addr = drv_word.phys_addr;
   assign req_chan.map_flags = drv_word.map_flags;
   assign rsp_chan.ready     = rsp_ready_q;

   page_table_map_unmap u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we_q),
      .csr_wdata (csr_wdata_q)
   );

   // ------------------------------------------------------------------
   // predictor state: its own table memory, allocator and pool base
   // ------------------------------------------------------------------
   bit [ptm_pkg::DESC_W-1:0]  table_mem [ptm_pkg::TABLE_DEPTH];
   int unsigned               next_table_page = 1;
   logic [ptm_pkg::PA_W-1:0]  pool_base       = '0;

   // words waiting for the driver, responses waiting for the monitor
   map_req_type pending_words [$];
   map_rsp_type expected_rsps [$];

   int words_queued   = 0;
   int words_accepted = 0;
   int rsp_count      = 0;
   int fail_count     = 0;

   // idle percentages, changed by the stimulus between phases
   int send_idle_pct = 29;
   int recv_idle_pct = 79;

   logic req_taken = 1'b0;

   // hot table indices so that most words land in tables that already exist
   logic [ptm_pkg::IDX_W-1:0] hot_l1 [3];
   logic [ptm_pkg::IDX_W-1:0] hot_l2 [3];

   // leaf descriptor from a physical page and the device / no-exec / user flags
   function automatic logic [ptm_pkg::DESC_W-1:0] leaf_desc(
      input logic [ptm_pkg::PA_W-1:0] pa, input logic [ptm_pkg::FLAGS_W-1:0] flags);
      logic [ptm_pkg::DESC_W-1:0] d;
      d = ({16'b0, pa} & ptm_pkg::ADDR_MASK) | ptm_pkg::DESC_VALID | ptm_pkg::BIT_AF;
      if (flags[0]) begin
         d |= ptm_pkg::ATTR_DEVICE;
      end else begin
         d |= ptm_pkg::SH_INNER_BITS;
      end
      if (flags[2]) begin
         // user page: never privileged-executable, user-exec unless no-exec
         d |= ptm_pkg::AP_USER_BIT | ptm_pkg::BIT_PXN;
         if (flags[1]) begin
            d |= ptm_pkg::BIT_UXN;
         end
      end else begin
         d |= ptm_pkg::BIT_UXN;
         if (flags[0] || flags[1]) begin
            d |= ptm_pkg::BIT_PXN;
         end
      end
      return d;
   endfunction

   // turn a table link into a pool page, -1 when it is no usable link
   // the offset is taken against the base as it stands now, modulo 2^48
   function automatic int link_target(input logic [ptm_pkg::DESC_W-1:0] e);
      logic [ptm_pkg::PA_W-1:0] off;
      if (e[1:0] != ptm_pkg::DESC_VALID[1:0]) begin
         return -1;
      end
      off = (e[ptm_pkg::PA_W-1:0] & FRAME_MASK) - (pool_base & FRAME_MASK);
      if (off[ptm_pkg::PA_W-1:12] < 1 || off[ptm_pkg::PA_W-1:12] >= next_table_page) begin
         return -1;
      end
      return int'(off[ptm_pkg::PA_W-1:12]);
   endfunction

   // follow the entry at page/idx, allocating and linking a fresh table when it is empty
   function automatic bit claim_child(input int page, input int idx, output int child,
                                      output logic [ptm_pkg::STATUS_W-1:0] err);
      int                         slot;
      logic [ptm_pkg::DESC_W-1:0] e;
      slot  = page * ENTRIES_PER_PAGE + idx;
      e     = table_mem[slot];
      child = -1;
      err   = ptm_pkg::ST_OK;
      if (e == '0) begin
         if (next_table_page >= ptm_pkg::TABLE_PAGES) begin
            err = ptm_pkg::ST_EXHAUSTED;
            return 1'b0;
         end
         child = int'(next_table_page);
         next_table_page++;
         for (int k = 0; k < ENTRIES_PER_PAGE; k++) begin
            table_mem[child * ENTRIES_PER_PAGE + k] = '0;
         end
         table_mem[slot] = {16'b0, ((pool_base & FRAME_MASK) + (ptm_pkg::PA_W'(child) << 12))
                                   & FRAME_MASK} | ptm_pkg::DESC_VALID;
         return 1'b1;
      end
      child = link_target(e);
      if (child < 0) begin
         // something sits here but it is no table we can use
         err = ptm_pkg::ST_MAPPED;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // apply one accepted word to the predictor tables and give the response it should cause
   function automatic map_rsp_type table_update(input map_req_type w);
      map_rsp_type                  r;
      int                           l2;
      int                           l3;
      int                           slot;
      logic [ptm_pkg::STATUS_W-1:0] err;
      logic [ptm_pkg::IDX_W-1:0]    i1;
      logic [ptm_pkg::IDX_W-1:0]    i2;
      logic [ptm_pkg::IDX_W-1:0]    i3;
      r.status          = ptm_pkg::ST_OK;
      r.page_descriptor = '0;
      i1 = w.virt_addr[38:30];
      i2 = w.virt_addr[29:21];
      i3 = w.virt_addr[20:12];
      if (w.func == ptm_pkg::FUNC_MAP) begin
         if (w.virt_addr[11:0] != 12'h0 || w.phys_addr[11:0] != 12'h0) begin
            r.status = ptm_pkg::ST_MISALIGNED;
         end else if (!claim_child(0, i1, l2, err)) begin
            r.status = err;
         end else if (!claim_child(l2, i2, l3, err)) begin
            // an l2 table linked on the way stays linked
            r.status = err;
         end else begin
            slot = l3 * ENTRIES_PER_PAGE + i3;
            if (table_mem[slot] != '0) begin
               r.status = ptm_pkg::ST_MAPPED;
            end else begin
               r.page_descriptor = leaf_desc(w.phys_addr, w.map_flags);
               table_mem[slot]   = r.page_descriptor;
            end
         end
      end else begin
         // unmap looks at the virtual address only
         if (w.virt_addr[11:0] != 12'h0) begin
            r.status = ptm_pkg::ST_MISALIGNED;
         end else begin
            l2 = link_target(table_mem[i1]);
            l3 = (l2 < 0) ? -1 : link_target(table_mem[l2 * ENTRIES_PER_PAGE + i2]);
            if (l3 < 0) begin
               r.status = ptm_pkg::ST_UNMAPPED;
            end else begin
               slot = l3 * ENTRIES_PER_PAGE + i3;
               if (table_mem[slot] == '0) begin
                  r.status = ptm_pkg::ST_UNMAPPED;
               end else begin
                  table_mem[slot] = '0;
               end
            end
         end
      end
      return r;
   endfunction

   // random word: mostly hot tables with a few leaf slots so maps and unmaps collide,
   // now and then a fresh table index that drives the allocator toward exhaustion
   function automatic map_req_type random_word();
      map_req_type               w;
      logic [ptm_pkg::IDX_W-1:0] l1;
      logic [ptm_pkg::IDX_W-1:0] l2;
      logic [ptm_pkg::IDX_W-1:0] l3;
      int                        pick;
      w.func = ($urandom_range(0, 99) < 55) ? ptm_pkg::FUNC_MAP : ptm_pkg::FUNC_UNMAP;
      l1 = hot_l1[$urandom_range(0, 2)];
      l2 = hot_l2[$urandom_range(0, 2)];
      l3 = ($urandom_range(0, 7) == 0) ? ptm_pkg::IDX_W'($urandom)
                                       : ptm_pkg::IDX_W'($urandom_range(0, 7));
      pick = $urandom_range(0, 63);
      if (pick == 0) begin
         l1 = ptm_pkg::IDX_W'($urandom);
         l2 = ptm_pkg::IDX_W'($urandom);
      end else if (pick == 1) begin
         l2 = ptm_pkg::IDX_W'($urandom);
      end
      w.virt_addr = {l1, l2, l3, 12'h000};
      w.phys_addr = ptm_pkg::PA_W'({$urandom, $urandom}) & FRAME_MASK;
      w.map_flags = ptm_pkg::FLAGS_W'($urandom);
      if ($urandom_range(0, 15) == 0) begin
         w.virt_addr[11:0] = 12'($urandom_range(1, 4095));
      end
      if ($urandom_range(0, 15) == 0) begin
         w.phys_addr[11:0] = 12'($urandom_range(1, 4095));
      end
      return w;
   endfunction

   // ------------------------------------------------------------------
   // clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // request driver: presents queued words at the falling edge, holds a word until taken
   // ------------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (!drv_valid || req_taken) begin
         if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            drv_word  <= pending_words.pop_front();
            drv_valid <= 1'b1;
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   // acceptance: every word taken at a rising edge goes through the predictor here
   always @(posedge clock) begin : req_capture
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            expected_rsps.push_back(table_update(drv_word));
            words_accepted++;
         end
      end
   end

   // ------------------------------------------------------------------
   // response side: random ready, plus one long hold-off counted here so the
   // output register fills and the block has to stall its request side
   // ------------------------------------------------------------------
   int  stall_left   = 0;
   bit  holdoff_done = 1'b0;

   always @(negedge clock) begin : rsp_ready_gen
      if (reset) begin
         rsp_ready_q <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left  <= stall_left - 1;
         rsp_ready_q <= 1'b0;
      end else if (!holdoff_done && rsp_count >= HOLDOFF_AFTER) begin
         stall_left   <= HOLDOFF_CYCLES;
         holdoff_done <= 1'b1;
         rsp_ready_q  <= 1'b0;
      end else begin
         rsp_ready_q <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // monitor: each response word against the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      map_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            $error("response word with nothing expected: status %0d, page_descriptor %h",
                   rsp_chan.status, rsp_chan.page_descriptor);
            fail_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_chan.status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d",
                      want.status, rsp_chan.status);
               fail_count++;
            end
            if (rsp_chan.page_descriptor !== want.page_descriptor) begin
               $error("page_descriptor mismatch: expected %h, actual %h",
                      want.page_descriptor, rsp_chan.page_descriptor);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   task automatic push_word(input logic func, input logic [ptm_pkg::VA_W-1:0] va,
                            input logic [ptm_pkg::PA_W-1:0] pa,
                            input logic [ptm_pkg::FLAGS_W-1:0] flags);
      map_req_type w;
      w.func      = func;
      w.virt_addr = va;
      w.phys_addr = pa;
      w.map_flags = flags;
      pending_words.push_back(w);
      words_queued++;
   endtask

   // the block registers the base on csr_we; the predictor follows at once
   task automatic write_pool_base(input logic [ptm_pkg::PA_W-1:0] value);
      @(negedge clock);
      csr_we_q    <= 1'b1;
      csr_wdata_q <= value;
      @(negedge clock);
      csr_we_q    <= 1'b0;
      pool_base    = value;
   endtask

   // wait until every queued word is taken and answered, then let the walk settle
   task automatic wait_idle();
      while (words_accepted != words_queued || expected_rsps.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic random_phase(input int n, input bit pause_midway);
      for (int k = 0; k < n; k++) begin
         if (pause_midway && k == n / 2) begin
            // sender holds back until the block has answered everything
            wait_idle();
         end
         pending_words.push_back(random_word());
         words_queued++;
      end
   endtask

   initial begin : stimulus
      hot_l1[0] = '0;
      hot_l1[1] = '1;
      hot_l1[2] = ptm_pkg::IDX_W'($urandom_range(1, 510));
      hot_l2[0] = '0;
      hot_l2[1] = '1;
      hot_l2[2] = ptm_pkg::IDX_W'($urandom_range(1, 510));

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // base zero, written while the block clears its table
      write_pool_base('0);

      // directed: map, double map, unmap, double unmap of the lowest page
      push_word(ptm_pkg::FUNC_MAP,   '0, '0, 3'd0);
      push_word(ptm_pkg::FUNC_MAP,   '0, 48'h0000_1234_5000, 3'd5);
      push_word(ptm_pkg::FUNC_UNMAP, '0, '0, 3'd0);
      push_word(ptm_pkg::FUNC_UNMAP, '0, '0, 3'd0);
      // every flag combination in neighbouring leaf slots
      for (int f = 0; f < 8; f++) begin
         push_word(ptm_pkg::FUNC_MAP, ptm_pkg::VA_W'((f + 1) << 12),
                   ptm_pkg::PA_W'(48'h0000_ABCD_E000 + (f << 12)), ptm_pkg::FLAGS_W'(f));
      end
      // top of both address spaces, all flags set
      push_word(ptm_pkg::FUNC_MAP,   39'h7F_FFFF_F000, 48'hFFFF_FFFF_F000, 3'd7);
      push_word(ptm_pkg::FUNC_UNMAP, 39'h7F_FFFF_F000, 48'hFFFF_FFFF_FFFF, 3'd7);
      // misaligned virtual, misaligned physical, misaligned unmap
      push_word(ptm_pkg::FUNC_MAP,   39'h7F_FFFF_FFFF, 48'h0000_0000_1000, 3'd0);
      push_word(ptm_pkg::FUNC_MAP,   39'h00_0000_9000, 48'hFFFF_FFFF_FFFF, 3'd3);
      push_word(ptm_pkg::FUNC_UNMAP, 39'h00_0000_0001, '0, 3'd0);
      // unmap ignores a misaligned physical address
      push_word(ptm_pkg::FUNC_UNMAP, 39'h00_0000_2000, 48'h0000_0000_0FFF, 3'd6);
      // unmap through a missing l2 table, then through a missing l3 table
      push_word(ptm_pkg::FUNC_UNMAP, {9'd300, 9'd0, 9'd0, 12'h000}, '0, 3'd0);
      push_word(ptm_pkg::FUNC_UNMAP, {9'd0, 9'd300, 9'd0, 12'h000}, '0, 3'd0);
      // unmap of an empty leaf in an existing table
      push_word(ptm_pkg::FUNC_UNMAP, 39'h00_0001_F000, '0, 3'd0);
      wait_idle();

      // random at base zero; the pool runs dry somewhere in here
      random_phase(PHASE_WORDS, 1'b0);
      wait_idle();

      // highest base: old links now decode to other pages or to nothing
      write_pool_base(48'hFFFF_FFFF_F000);
      random_phase(PHASE_WORDS, 1'b1);
      wait_idle();

      // unaligned base, whose low bits are dropped, so the first links work again
      send_idle_pct = 79;
      recv_idle_pct = 29;
      write_pool_base(ptm_pkg::PA_W'($urandom_range(1, 4095)));
      random_phase(PHASE_WORDS, 1'b0);
      wait_idle();

      // arbitrary base
      write_pool_base(ptm_pkg::PA_W'({$urandom, $urandom}));
      random_phase(PHASE_WORDS, 1'b0);
      wait_idle();

      // back to zero with no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_pool_base('0);
      random_phase(PHASE_WORDS, 1'b0);
      wait_idle();

      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run including the clearing sweep
   initial begin : watchdog
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
